/* rtl/msst_pkg.sv */
// ---------------------------------------------------------------------------
// msst_pkg
// Shared types and constants for the minimum slimness spanning tree block.
// ---------------------------------------------------------------------------
package msst_pkg;

    localparam int VERT_W   = 7;
    localparam int WEIGHT_W = 16;

    // controller to datapath
    typedef struct packed {
        logic load_edge;    // write the incoming edge at the fill count
        logic clear_count;  // drop the stored edge list
        logic sort_start;   // begin the insertion sort
    } msst_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic busy;                   // sort or passes still running
        logic no_tree;
        logic [WEIGHT_W-1:0] slimness;
    } msst_sts_t;

endpackage

/* rtl/min_slimness_spanning_tree.sv */
// ---------------------------------------------------------------------------
// min_slimness_spanning_tree
// Stores edges, then finds the spanning tree of least weight spread.
// ---------------------------------------------------------------------------
// Edge requests are taken back to back, one per cycle, while loading; once the
// closing request is taken no more are accepted until the result is taken. The
// block then runs an insertion sort of the stored edges and, per start edge, a
// parent table init sweep, find and compress steps for both ends of each edge,
// and a root check per vertex for the span; then the result is offered.
// Reset clears control state only; no clearing pass is needed.
module min_slimness_spanning_tree #(
    parameter int MAX_VERTICES = 128,
    parameter int MAX_EDGES    = 8192
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,    // vertex_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,      // end_a[6:0], end_b[13:7], weight[29:14]
    input  logic        s_tuser,      // has_edge
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // slimness
    output logic        m_tuser       // no_tree
);
    import msst_pkg::*;

    logic [VERT_W-1:0] n_reg;
    msst_cmd_t cmd;
    msst_sts_t sts;
    logic [WEIGHT_W:0] result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= VERT_W'(2);
        end else if (cfg_we) begin
            n_reg <= cfg_wdata;
        end
    end

    msst_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready,
        .has_edge(s_tuser), .last(s_tlast),
        .m_tvalid, .m_tready, .cmd, .sts, .result
    );

    msst_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
        .aclk, .aresetn, .cmd,
        .in_a(s_tdata[6:0]), .in_b(s_tdata[13:7]), .in_w(s_tdata[29:14]),
        .n_cfg(n_reg), .sts
    );

    assign m_tdata = result[WEIGHT_W-1:0];
    assign m_tuser = result[WEIGHT_W];

endmodule

/* rtl/msst_datapath.sv */
// ---------------------------------------------------------------------------
// msst_datapath
// Edge memory, insertion sort, Kruskal passes with a union-find table.
// ---------------------------------------------------------------------------
module msst_datapath #(
    parameter int MAX_VERTICES = 128,
    parameter int MAX_EDGES    = 8192
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  msst_pkg::msst_cmd_t      cmd,
    input  logic [msst_pkg::VERT_W-1:0]   in_a,
    input  logic [msst_pkg::VERT_W-1:0]   in_b,
    input  logic [msst_pkg::WEIGHT_W-1:0] in_w,
    input  logic [msst_pkg::VERT_W-1:0]   n_cfg,
    output msst_pkg::msst_sts_t      sts
);
    import msst_pkg::*;

    localparam int AW  = $clog2(MAX_EDGES);
    localparam int CW  = AW + 1;
    localparam int PW  = $clog2(MAX_VERTICES);
    localparam int EW  = 2 * VERT_W + WEIGHT_W;

    // sequencer codes
    localparam logic [3:0] D_IDLE = 4'd0,
                           D_SRD  = 4'd1,  // read element j-1 for the sort
                           D_SCMP = 4'd2,
                           D_INIT = 4'd3,  // parent table init sweep
                           D_ERD  = 4'd4,  // read edge j
                           D_FA   = 4'd5,  // find root of a
                           D_FB   = 4'd6,  // find root of b
                           D_CA   = 4'd7,  // compress path of a
                           D_CB   = 4'd8,  // compress path of b
                           D_UN   = 4'd9,
                           D_CHK  = 4'd10, // root check per vertex
                           D_CHK2 = 4'd11,
                           D_SRD2 = 4'd12,
                           D_CCMP = 4'd13;

    logic [EW-1:0] mem [MAX_EDGES];
    logic [EW-1:0] rdata_reg;
    logic [PW-1:0] par [MAX_VERTICES];
    logic [PW-1:0] prd_reg;

    logic [3:0]    st_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] i_reg, j_reg;
    logic [EW-1:0] key_reg;
    logic [WEIGHT_W-1:0] start_w_reg, largest_reg;
    logic [16:0]   best_reg;
    logic [PW-1:0] v_reg, ra_reg, rb_reg, ea_reg, eb_reg, k_reg;
    logic          busy_reg, spans_reg;

    // memory port controls
    logic          mwe;
    logic [AW-1:0] mwa, mra;
    logic [EW-1:0] mwd;
    logic          pwe;
    logic [PW-1:0] pwa, pra;
    logic [PW-1:0] pwd;

    logic          edge_ok;
    logic [PW-1:0] n_lim;
    assign n_lim = (32'(n_cfg) > 32'(MAX_VERTICES - 1)) ? PW'(MAX_VERTICES - 1)
                                                        : PW'(n_cfg);

    assign edge_ok = (cnt_reg < CW'(MAX_EDGES)) && in_a != '0 && in_b != '0
                   && in_a <= n_cfg && in_b <= n_cfg
                   && 32'(in_a) < 32'(MAX_VERTICES)
                   && 32'(in_b) < 32'(MAX_VERTICES);

    always_ff @(posedge aclk) begin
        if (mwe) begin
            mem[mwa] <= mwd;
        end
        rdata_reg <= mem[mra];
        if (pwe) begin
            par[pwa] <= pwd;
        end
        prd_reg <= par[pra];
    end

    logic [WEIGHT_W-1:0] rd_w, key_w;
    assign rd_w  = rdata_reg[WEIGHT_W-1:0];
    assign key_w = key_reg[WEIGHT_W-1:0];

    always_comb begin
        mwe = 1'b0; mwa = cnt_reg[AW-1:0]; mwd = {in_a, in_b, in_w};
        mra = '0;
        pwe = 1'b0; pwa = k_reg; pwd = k_reg; pra = v_reg;
        if (cmd.load_edge && edge_ok) begin
            mwe = 1'b1;
        end
        case (st_reg)
            D_SRD:  mra = AW'(j_reg - CW'(1));
            D_SRD2: mra = AW'(i_reg);
            D_SCMP: begin
                mwa = AW'(j_reg);
                if (j_reg != '0 && rd_w > key_w) begin
                    mwd = rdata_reg; mwe = 1'b1;
                end else begin
                    mwd = key_reg; mwe = 1'b1;
                end
            end
            D_INIT: pwe = 1'b1;
            D_ERD:  mra = AW'(j_reg);
            D_CA: begin
                pwe = 1'b1; pwa = v_reg; pwd = ra_reg;
            end
            D_CB: begin
                pwe = 1'b1; pwa = v_reg; pwd = rb_reg;
            end
            D_UN: begin
                pwe = (ra_reg != rb_reg);
                pwa = (ra_reg > rb_reg) ? ra_reg : rb_reg;
                pwd = (ra_reg > rb_reg) ? rb_reg : ra_reg;
            end
            default: ;
        endcase
    end

    // each find step is an address phase then a registered read
    logic fph_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= D_IDLE;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            best_reg <= '1;
            fph_reg  <= 1'b0;
        end else begin
            if (cmd.load_edge && edge_ok) begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.clear_count) begin
                cnt_reg <= '0;
            end
            case (st_reg)
                D_IDLE: begin
                    if (cmd.sort_start) begin
                        busy_reg <= 1'b1;
                        best_reg <= '1;
                        i_reg    <= CW'(1);
                        st_reg   <= (cnt_reg > CW'(1)) ? D_SRD2 : D_INIT;
                        k_reg    <= '0;
                        if (cnt_reg <= CW'(1)) begin
                            i_reg <= '0;
                            if (cnt_reg == '0) st_reg <= D_CCMP;
                        end
                    end
                end
                D_SRD2: begin
                    fph_reg <= ~fph_reg;
                    if (fph_reg) begin
                        key_reg <= rdata_reg;
                        j_reg   <= i_reg;
                        fph_reg <= 1'b0;
                        st_reg  <= D_SRD;
                    end
                end
                D_SRD: begin
                    fph_reg <= ~fph_reg;
                    if (fph_reg) begin
                        fph_reg <= 1'b0;
                        st_reg  <= D_SCMP;
                    end
                end
                D_SCMP: begin
                    if (j_reg != '0 && rd_w > key_w) begin
                        j_reg <= j_reg - CW'(1);
                        st_reg <= (j_reg == CW'(1)) ? D_SCMP : D_SRD;
                    end else if (i_reg + CW'(1) < cnt_reg) begin
                        i_reg  <= i_reg + CW'(1);
                        st_reg <= D_SRD2;
                    end else begin
                        i_reg  <= '0;
                        k_reg  <= '0;
                        st_reg <= D_INIT;
                    end
                end
                D_INIT: begin
                    k_reg <= k_reg + PW'(1);
                    if (k_reg == PW'(MAX_VERTICES - 1)) begin
                        j_reg       <= i_reg;
                        largest_reg <= '0;
                        fph_reg     <= 1'b0;
                        st_reg      <= D_ERD;
                    end
                end
                D_ERD: begin
                    fph_reg <= ~fph_reg;
                    if (fph_reg) begin
                        fph_reg <= 1'b0;
                        if (j_reg == i_reg) start_w_reg <= rd_w;
                        ea_reg <= PW'(rdata_reg[EW-1 -: VERT_W]);
                        eb_reg <= PW'(rdata_reg[WEIGHT_W +: VERT_W]);
                        v_reg  <= PW'(rdata_reg[EW-1 -: VERT_W]);
                        key_reg <= rdata_reg;
                        st_reg <= D_FA;
                    end
                end
                D_FA: begin
                    fph_reg <= ~fph_reg;
                    if (fph_reg) begin
                        fph_reg <= 1'b0;
                        if (prd_reg == v_reg) begin
                            ra_reg <= v_reg; v_reg <= ea_reg; st_reg <= D_CA;
                        end else begin
                            v_reg <= prd_reg;
                        end
                    end
                end
                D_CA: begin
                    // hold the walk: read parent of v then point v at the root
                    fph_reg <= ~fph_reg;
                    if (fph_reg) begin
                        fph_reg <= 1'b0;
                        if (v_reg == ra_reg) begin
                            v_reg <= eb_reg; st_reg <= D_FB;
                        end else begin
                            v_reg <= prd_reg;
                        end
                    end
                end
                D_FB: begin
                    fph_reg <= ~fph_reg;
                    if (fph_reg) begin
                        fph_reg <= 1'b0;
                        if (prd_reg == v_reg) begin
                            rb_reg <= v_reg; v_reg <= eb_reg; st_reg <= D_CB;
                        end else begin
                            v_reg <= prd_reg;
                        end
                    end
                end
                D_CB: begin
                    fph_reg <= ~fph_reg;
                    if (fph_reg) begin
                        fph_reg <= 1'b0;
                        if (v_reg == rb_reg) begin
                            st_reg <= D_UN;
                        end else begin
                            v_reg <= prd_reg;
                        end
                    end
                end
                D_UN: begin
                    if (ra_reg != rb_reg && key_w > largest_reg) begin
                        largest_reg <= key_w;
                    end
                    if (j_reg + CW'(1) < cnt_reg) begin
                        j_reg  <= j_reg + CW'(1);
                        st_reg <= D_ERD;
                    end else begin
                        spans_reg <= 1'b1;
                        k_reg     <= PW'(1);
                        v_reg     <= PW'(1);
                        st_reg    <= D_CHK;
                    end
                end
                D_CHK: begin
                    // plain root walk; compression here is not observable
                    fph_reg <= ~fph_reg;
                    if (fph_reg) begin
                        fph_reg <= 1'b0;
                        if (prd_reg == v_reg) begin
                            if (v_reg != PW'(1)) spans_reg <= 1'b0;
                            st_reg <= D_CHK2;
                        end else begin
                            v_reg <= prd_reg;
                        end
                    end
                end
                D_CHK2: begin
                    if (spans_reg && k_reg < n_lim) begin
                        k_reg  <= k_reg + PW'(1);
                        v_reg  <= k_reg + PW'(1);
                        st_reg <= D_CHK;
                    end else begin
                        if (spans_reg && largest_reg >= start_w_reg &&
                            {1'b0, largest_reg - start_w_reg} < best_reg) begin
                            best_reg <= {1'b0, largest_reg - start_w_reg};
                        end
                        if (i_reg + CW'(1) < cnt_reg) begin
                            i_reg  <= i_reg + CW'(1);
                            k_reg  <= '0;
                            st_reg <= D_INIT;
                        end else begin
                            st_reg <= D_CCMP;
                        end
                    end
                end
                D_CCMP: begin
                    busy_reg <= 1'b0;
                    st_reg   <= D_IDLE;
                end
                default: st_reg <= D_IDLE;
            endcase
        end
    end

    assign sts.busy     = busy_reg || cmd.sort_start;
    assign sts.no_tree  = (n_lim >= PW'(2)) && (best_reg == '1);
    assign sts.slimness = (n_lim < PW'(2) || best_reg == '1) ? '0
                                                             : best_reg[WEIGHT_W-1:0];

    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == D_IDLE) |-> (fph_reg == 1'b0))
        else $error("find phase left mid step");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == D_SCMP) |-> (j_reg < cnt_reg))
        else $error("sort index beyond fill");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != D_IDLE) |-> busy_reg)
        else $error("sequencer active while idle flag low");

endmodule

/* rtl/msst_ctrl.sv */
// ---------------------------------------------------------------------------
// msst_ctrl
// Request sequencing: load, launch compute, hold result for the output side.
// ---------------------------------------------------------------------------
module msst_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  has_edge,
    input  logic                  last,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output msst_pkg::msst_cmd_t   cmd,
    input  msst_pkg::msst_sts_t   sts,
    output logic [msst_pkg::WEIGHT_W:0] result
);
    import msst_pkg::*;

    localparam logic [1:0] C_LOAD = 2'd0,
                           C_RUN  = 2'd1,
                           C_WAIT = 2'd2,
                           C_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [WEIGHT_W:0] res_reg;
    logic acc;

    assign s_tready = (state_reg == C_LOAD);
    assign acc      = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == C_OUT);
    assign result   = res_reg;

    always_comb begin
        cmd = '0;
        cmd.load_edge  = acc && has_edge;
        cmd.sort_start = (state_reg == C_RUN);
        cmd.clear_count = (state_reg == C_WAIT) && !sts.busy;
        state_next = state_reg;
        case (state_reg)
            C_LOAD: if (acc && last) state_next = C_RUN;
            C_RUN:  state_next = C_WAIT;
            C_WAIT: if (!sts.busy) state_next = C_OUT;
            C_OUT:  if (m_tready) state_next = C_LOAD;
            default: state_next = C_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_LOAD;
        end else begin
            state_reg <= state_next;
        end
        if (state_reg == C_WAIT && !sts.busy) begin
            res_reg <= {sts.no_tree, sts.slimness};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == C_RUN) |=> (state_reg == C_WAIT))
        else $error("launch not followed by wait");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped");

endmodule

/* dv/min_slimness_spanning_tree_test.sv */
// ---------------------------------------------------------------------------
// min_slimness_spanning_tree_test
// Self-checking bench: loads random and directed graphs, predicts the minimum
// slimness with its own Kruskal/union-find predictor, and checks each result.
// ---------------------------------------------------------------------------
module min_slimness_spanning_tree_test;
    timeunit 1ns;
    timeprecision 1ps;

    import msst_pkg::*;

    localparam int NUM_VERT  = 128;
    localparam int NUM_EDGES = 8192;
    localparam int CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic                no_tree;
        logic [WEIGHT_W-1:0] slimness;
    } slim_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;

    min_slimness_spanning_tree i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // predictor state
    logic [6:0]          vert_count;
    logic [6:0]          edge_a [NUM_EDGES];
    logic [6:0]          edge_b [NUM_EDGES];
    logic [WEIGHT_W-1:0] edge_w [NUM_EDGES];
    int unsigned         stored_edges;
    int unsigned         parent [NUM_VERT];

    slim_result_t expected_slim [$];
    int unsigned  error_count;
    int unsigned  result_count;
    int unsigned  request_count;
    int unsigned  tree_count;
    int unsigned  cycle_count;
    int unsigned  sender_idle_pct;
    int unsigned  recv_stall_pct;

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic int unsigned find_root(int unsigned v);
        int unsigned r;
        int unsigned t;
        int unsigned nx;
        int unsigned guard;
        r = v;
        guard = 0;
        while (r < NUM_VERT && parent[r] != r && guard < NUM_VERT) begin
            r = parent[r];
            guard++;
        end
        t = v;
        guard = 0;
        while (t < NUM_VERT && parent[t] != t && guard < NUM_VERT) begin
            nx = parent[t];
            parent[t] = r;
            t = nx;
            guard++;
        end
        return r;
    endfunction

    function automatic slim_result_t compute_slimness();
        slim_result_t        res;
        int unsigned         n;
        int unsigned         best;
        int unsigned         widest;
        int unsigned         ra;
        int unsigned         rb;
        int                  j;
        logic [6:0]          ta;
        logic [6:0]          tb;
        logic [WEIGHT_W-1:0] tw;
        bit                  spans;
        res = '0;
        n = vert_count;
        if (n < 2) return res;
        for (int i = 1; i < stored_edges; i++) begin
            ta = edge_a[i];
            tb = edge_b[i];
            tw = edge_w[i];
            j = i;
            while (j > 0 && edge_w[j-1] > tw) begin
                edge_a[j] = edge_a[j-1];
                edge_b[j] = edge_b[j-1];
                edge_w[j] = edge_w[j-1];
                j--;
            end
            edge_a[j] = ta;
            edge_b[j] = tb;
            edge_w[j] = tw;
        end
        best = 32'h1FFFF;
        for (int i = 0; i < stored_edges; i++) begin
            widest = 0;
            for (int k = 0; k < NUM_VERT; k++) parent[k] = k;
            for (int e = i; e < stored_edges; e++) begin
                ra = find_root(edge_a[e]);
                rb = find_root(edge_b[e]);
                if (ra != rb) begin
                    // smaller root wins
                    if (ra > rb) parent[ra] = rb;
                    else parent[rb] = ra;
                    if (edge_w[e] > widest) widest = edge_w[e];
                end
            end
            spans = 1'b1;
            for (int k = 1; k <= n; k++) begin
                if (find_root(k) != 1) begin
                    spans = 1'b0;
                    break;
                end
            end
            if (spans && widest >= edge_w[i] && widest - edge_w[i] < best)
                best = widest - edge_w[i];
        end
        if (best == 32'h1FFFF) res.no_tree = 1'b1;
        else res.slimness = best[15:0];
        return res;
    endfunction

    function automatic void predict_request(bit has_edge, logic [6:0] a, logic [6:0] b,
                                            logic [15:0] w, bit last);
        if (has_edge && stored_edges < NUM_EDGES && a >= 1 && b >= 1 &&
            a <= vert_count && b <= vert_count) begin
            edge_a[stored_edges] = a;
            edge_b[stored_edges] = b;
            edge_w[stored_edges] = w;
            stored_edges++;
        end
        if (last) begin
            expected_slim.insert(expected_slim.size(), compute_slimness());
            stored_edges = 0;
        end
    endfunction

    // called and returns at a falling edge
    task automatic send_request(bit has_edge, logic [6:0] a, logic [6:0] b,
                                logic [15:0] w, bit last);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, w, b, a};
        s_tuser  <= has_edge;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_request(has_edge, a, b, w, last);
        request_count++;
        @(negedge aclk);
    endtask

    task automatic send_edge(logic [6:0] a, logic [6:0] b, logic [15:0] w, bit last);
        send_request(1'b1, a, b, w, last);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_slim.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_vertex_count(logic [6:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        vert_count = value;
        @(negedge aclk);
    endtask

    // receiver stalls
    always @(negedge aclk) begin
        if (aresetn) m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        slim_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (expected_slim.size() == 0) begin
                $error("result with no request pending: slimness %0d no_tree %0d",
                       m_tdata, m_tuser);
                error_count++;
            end else begin
                want = expected_slim.pop_front();
                if (!want.no_tree) tree_count++;
                if (m_tdata !== want.slimness) begin
                    $error("slimness: expected %0d, got %0d", want.slimness, m_tdata);
                    error_count++;
                end
                if (m_tuser !== want.no_tree) begin
                    $error("no_tree: expected %0d, got %0d", want.no_tree, m_tuser);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_small_counts();
        write_vertex_count(7'd0);
        send_edge(7'd1, 7'd1, 16'd5, 1'b1);
        write_vertex_count(7'd1);
        send_edge(7'd1, 7'd1, 16'd9, 1'b0);
        send_request(1'b0, 7'd0, 7'd0, 16'd0, 1'b1);
    endtask

    task automatic test_empty_and_markers();
        write_vertex_count(7'd2);
        send_request(1'b0, 7'd0, 7'd0, 16'd0, 1'b1);
        // neither edge nor end: no effect
        send_request(1'b0, 7'h7F, 7'h7F, 16'hFFFF, 1'b0);
        send_edge(7'd1, 7'd2, 16'hFFFF, 1'b0);
        send_request(1'b0, 7'd0, 7'd0, 16'd0, 1'b1);
    endtask

    task automatic test_edge_cases();
        write_vertex_count(7'd4);
        send_edge(7'd0, 7'd1, 16'd1, 1'b0);        // endpoint zero, dropped
        send_edge(7'd5, 7'd2, 16'd1, 1'b0);        // endpoint above count, dropped
        send_edge(7'd3, 7'd3, 16'd0, 1'b0);        // self loop
        send_edge(7'd1, 7'd2, 16'hFFFF, 1'b0);
        send_edge(7'd2, 7'd3, 16'd0, 1'b0);
        send_edge(7'd3, 7'd4, 16'd7, 1'b0);
        send_edge(7'd4, 7'd1, 16'd7, 1'b0);        // tie
        send_edge(7'd2, 7'd4, 16'd7, 1'b1);
        send_edge(7'd1, 7'd2, 16'd3, 1'b0);
        send_edge(7'd3, 7'd4, 16'd3, 1'b1);        // disconnected
    endtask

    task automatic test_largest_graph();
        write_vertex_count(7'd127);
        for (int v = 1; v < 127; v++)
            send_edge(v[6:0], 7'(v + 1), 16'($urandom_range(65535)), 1'b0);
        send_edge(7'd127, 7'd1, 16'($urandom_range(65535)), 1'b0);
        send_edge(7'd127, 7'd64, 16'hFFFF, 1'b1);
    endtask

    task automatic test_random_graphs(int unsigned num_requests);
        int unsigned sent;
        int unsigned edges;
        int unsigned vc;
        logic [6:0]  a;
        logic [6:0]  b;
        logic [15:0] w;
        bit          tie_heavy;
        sent = 0;
        while (sent < num_requests) begin
            vc = vert_count;
            edges = $urandom_range(vc + 4);
            tie_heavy = $urandom_range(1);
            for (int e = 0; e <= edges; e++) begin
                if ($urandom_range(19) == 0) begin
                    send_request(1'b0, 7'($urandom), 7'($urandom), 16'($urandom), 1'b0);
                    sent++;
                end
                if ($urandom_range(19) == 0) begin
                    a = 7'($urandom);
                    b = 7'($urandom);
                end else begin
                    a = 7'($urandom_range(vc, 1));
                    b = 7'($urandom_range(vc, 1));
                end
                w = tie_heavy ? 16'($urandom_range(15)) : 16'($urandom);
                if (e == edges && $urandom_range(3) == 0)
                    send_request(1'b0, 7'($urandom), 7'($urandom), 16'($urandom), 1'b1);
                else
                    send_edge(a, b, w, e == edges);
                sent++;
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        vert_count = 7'd2;
        stored_edges = 0;
        error_count = 0;
        result_count = 0;
        request_count = 0;
        tree_count = 0;
        cycle_count = 0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_small_counts();
        test_empty_and_markers();
        test_edge_cases();
        test_largest_graph();
        for (int phase = 0; phase < 8; phase++) begin
            write_vertex_count(phase == 0 ? 7'd2 : 7'($urandom_range(9, 2)));
            case (phase % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin sender_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            test_random_graphs(155);
        end

        drain_results();
        repeat (50) @(negedge aclk);
        $display("sent %0d requests, checked %0d results (%0d with a spanning tree)",
                 request_count, result_count, tree_count);
        $display("vertex counts 0 to 127, ties, self loops, dropped endpoints, idle mixes");
        if (error_count == 0 && expected_slim.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
